// ===== hdl/mcpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mcpwm_pkg
// Shared types and constants for the multi-channel PWM ramp / H-bridge block.
// ----------------------------------------------------------------------------
package mcpwm_pkg;

    localparam int CHANNEL_COUNT_DEF = 3;
    localparam int CH_W              = 2;
    localparam int DUTY_W            = 8;
    localparam int DIR_W             = 2;
    localparam int CFG_IDX_W         = 2;
    localparam int IN_TDATA_W        = 16;
    localparam int OUT_TDATA_W       = 40;

    localparam logic [DUTY_W-1:0] RAMP_STEP_RST  = 8'd5;
    localparam logic [DUTY_W-1:0] SLEW_LIMIT_RST = 8'd25;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RST   = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_STEP  = 2'd0,
        CFG_SLEW_LIMIT = 2'd1,
        CFG_DUTY_MAX   = 2'd2
    } t_cfg_idx;

    typedef enum logic [DIR_W-1:0] {
        DIR_STOP     = 2'd0,
        DIR_FWD      = 2'd1,
        DIR_REV      = 2'd2,
        DIR_STOP_ALT = 2'd3
    } t_dir;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic              enable;
        logic [DUTY_W-1:0] requested_duty;
        t_dir              direction;
    } t_item;

    typedef struct packed {
        logic [CH_W-1:0]   out_channel;
        logic [DUTY_W-1:0] limited_target;
        logic [DUTY_W-1:0] ramp_level;
        logic [DUTY_W-1:0] leg_a_duty;
        logic [DUTY_W-1:0] leg_b_duty;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_item   item;
    } t_item_word;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_result_word;

endpackage

// ===== hdl/mcpwm_in_stage.sv =====
// ----------------------------------------------------------------------------
// mcpwm_in_stage
// Input register: captures one slave-side request word per cycle while ready.
// ----------------------------------------------------------------------------
module mcpwm_in_stage
    import mcpwm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                  i_adv,
    output t_item_word            o_word
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign s_axis_tready = !r_valid || i_adv;

    always_comb begin
        n_item.channel        = s_axis_tdata[1:0];
        n_item.enable         = s_axis_tdata[2];
        n_item.requested_duty = s_axis_tdata[10:3];
        n_item.direction      = t_dir'(s_axis_tdata[12:11]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item <= n_item;
        end
    end

    assign o_word.valid = r_valid;
    assign o_word.item  = r_item;

endmodule

// ===== hdl/mcpwm_update.sv =====
// ----------------------------------------------------------------------------
// mcpwm_update
// Per-channel target/duty state, config registers and the slew, ramp and
// leg-select logic for one word.
// ----------------------------------------------------------------------------
module mcpwm_update
    import mcpwm_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DUTY_W-1:0]    i_cfg_wdata,
    input  t_item_word           i_word,
    input  logic                 i_adv,
    output t_result_word         o_word
);

    localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    logic [DUTY_W-1:0] r_ramp_step;
    logic [DUTY_W-1:0] r_slew_limit;
    logic [DUTY_W-1:0] r_duty_max;

    logic [DUTY_W-1:0] r_target [CHANNEL_COUNT];
    logic [DUTY_W-1:0] r_duty   [CHANNEL_COUNT];

    t_item             item;
    logic              in_range;
    logic [IDX_W-1:0]  idx;
    logic [DUTY_W-1:0] last_tgt;
    logic [DUTY_W-1:0] cur_duty;
    logic [DUTY_W-1:0] diff;
    logic [DUTY_W-1:0] tgt;
    logic [DUTY_W:0]   up_sum;
    logic [DUTY_W-1:0] lvl;
    logic [DUTY_W-1:0] capped;
    logic [DUTY_W-1:0] n_duty;
    logic              fire;

    assign item     = i_word.item;
    assign in_range = 32'(item.channel) < CHANNEL_COUNT;
    assign idx      = IDX_W'(item.channel);
    assign fire     = i_word.valid && i_adv && in_range;

    always_comb begin
        last_tgt = in_range ? r_target[idx] : '0;
        cur_duty = in_range ? r_duty[idx]   : '0;
    end

    // slew limit on the requested duty
    always_comb begin
        if (item.requested_duty > last_tgt) begin
            diff = item.requested_duty - last_tgt;
            tgt  = (diff > r_slew_limit) ? last_tgt + r_slew_limit : item.requested_duty;
        end else begin
            diff = last_tgt - item.requested_duty;
            tgt  = (diff > r_slew_limit) ? last_tgt - r_slew_limit : item.requested_duty;
        end
    end

    // ramp toward the limited target, never past it
    always_comb begin
        up_sum = {1'b0, cur_duty} + {1'b0, r_ramp_step};
        if (cur_duty < tgt) begin
            lvl = (up_sum > {1'b0, tgt}) ? tgt : up_sum[DUTY_W-1:0];
        end else if (cur_duty > tgt) begin
            lvl = ((cur_duty - tgt) <= r_ramp_step) ? tgt : cur_duty - r_ramp_step;
        end else begin
            lvl = cur_duty;
        end
        capped = (lvl > r_duty_max) ? r_duty_max : lvl;
        n_duty = item.enable ? lvl : '0;
    end

    always_comb begin
        o_word.valid              = i_word.valid && in_range;
        o_word.res.out_channel    = item.channel;
        o_word.res.limited_target = item.enable ? tgt : '0;
        o_word.res.ramp_level     = n_duty;
        o_word.res.leg_a_duty     = '0;
        o_word.res.leg_b_duty     = '0;
        if (item.enable) begin
            unique case (item.direction)
                DIR_FWD:      o_word.res.leg_a_duty = capped;
                DIR_REV:      o_word.res.leg_b_duty = capped;
                DIR_STOP,
                DIR_STOP_ALT: ;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_step  <= RAMP_STEP_RST;
            r_slew_limit <= SLEW_LIMIT_RST;
            r_duty_max   <= DUTY_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RAMP_STEP:  r_ramp_step  <= i_cfg_wdata;
                CFG_SLEW_LIMIT: r_slew_limit <= i_cfg_wdata;
                CFG_DUTY_MAX:   r_duty_max   <= i_cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                r_target[i] <= '0;
                r_duty[i]   <= '0;
            end
        end else if (fire) begin
            r_duty[idx] <= n_duty;
            if (item.enable) begin
                r_target[idx] <= tgt;
            end
        end
    end

    a_no_result_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_word.valid && !in_range) |-> !o_word.valid)
        else $error("result raised for channel out of range");

    a_one_leg_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word.valid |-> (o_word.res.leg_a_duty == '0 || o_word.res.leg_b_duty == '0))
        else $error("both bridge legs driven");

    a_slew_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.valid && item.enable) |->
            ((tgt >= last_tgt) ? (tgt - last_tgt <= r_slew_limit)
                               : (last_tgt - tgt <= r_slew_limit)))
        else $error("target step exceeds slew limit");

    a_leg_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word.valid |-> (o_word.res.leg_a_duty <= r_duty_max
                          && o_word.res.leg_b_duty <= r_duty_max))
        else $error("leg duty above ceiling");

endmodule

// ===== hdl/mcpwm_out_stage.sv =====
// ----------------------------------------------------------------------------
// mcpwm_out_stage
// Result register toward the master side; sets the advance of the pipeline.
// ----------------------------------------------------------------------------
module mcpwm_out_stage
    import mcpwm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_result_word           i_word,
    output logic                   o_adv,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic    r_valid;
    t_result r_res;

    assign o_adv = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_word.valid) begin
            r_res <= i_word.res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {6'b0, r_res.leg_b_duty, r_res.leg_a_duty, r_res.ramp_level,
                            r_res.limited_target, r_res.out_channel};

endmodule

// ===== hdl/multi_channel_pwm_ramp_h_bridge.sv =====
// ----------------------------------------------------------------------------
// multi_channel_pwm_ramp_h_bridge
// Slew-limited, ramped PWM duty per motor channel, steered to H-bridge legs.
//
//   side    port group   fields (tdata, low bit first)
//   ------  -----------  ---------------------------------------------------
//   in      s_axis       channel[1:0] enable[2] requested_duty[10:3]
//                        direction[12:11], zero fill to 16
//   out     m_axis       out_channel[1:0] limited_target[9:2] ramp_level[17:10]
//                        leg_a_duty[25:18] leg_b_duty[33:26], zero fill to 40
//   config  i_cfg_*      0 ramp_step, 1 slew_limit, 2 duty_max
//
// One word per cycle sustained while m_axis_tready stays high; a result word
// passes the input register, then the result register, with the channel state
// read and written while the word sits in the input register.
// Reset clears all channel state and loads the register defaults.
// A stalled result register holds the input register, which then holds
// s_axis_tready low. Out-of-range channels pass through and give no word.
// ----------------------------------------------------------------------------
module multi_channel_pwm_ramp_h_bridge
    import mcpwm_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [DUTY_W-1:0]      i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // channel, enable, requested_duty, direction
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_channel, limited_target, ramp_level, leg_a_duty, leg_b_duty
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_item_word   in_word;
    t_result_word res_word;
    logic         adv;

    mcpwm_in_stage u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_adv         (adv),
        .o_word        (in_word)
    );

    mcpwm_update #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_word      (in_word),
        .i_adv       (adv),
        .o_word      (res_word)
    );

    mcpwm_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_word        (res_word),
        .o_adv         (adv),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level bench for the multi-channel PWM ramp / H-bridge block. A short
// table of directed words (reset behaviour, extremes, disable, ignored
// channel, zero steps, odd direction) runs first. Several phases of random
// words under different register settings follow, with random idling on both
// sides, a long output hold-off and a full drain. Every result word is checked
// field by field against the table or an in-bench model of the per-channel slew and ramp.
// ----------------------------------------------------------------------------
module tb;
    import mcpwm_pkg::*;

    localparam int TIMEOUT_NS   = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 7;
    localparam int PHASE_WORDS  = 165;
    localparam int MAX_PRINTS   = 40;

    typedef enum {CHK_PREDICT, CHK_TYPED, CHK_SILENT} t_chk_kind;

    typedef struct {
        bit          cfg_write;
        t_cfg_idx    idx;
        int          value;
        int          ch;
        bit          en;
        int          req;
        t_dir        dir;
        t_chk_kind   kind;
        t_result     want;
    } t_plan_row;

    typedef struct {
        t_chk_kind kind;
        t_result   want;
    } t_typed_chk;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [DUTY_W-1:0]      i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // model copy of registers and channel state
    logic [DUTY_W-1:0] ramp_step_q  = RAMP_STEP_RST;
    logic [DUTY_W-1:0] slew_limit_q = SLEW_LIMIT_RST;
    logic [DUTY_W-1:0] duty_max_q   = DUTY_MAX_RST;
    logic [DUTY_W-1:0] target_mem [CHANNEL_COUNT_DEF] = '{default: '0};
    logic [DUTY_W-1:0] duty_mem   [CHANNEL_COUNT_DEF] = '{default: '0};

    t_result    due_bridge_words [$];
    t_typed_chk typed_checks [$];

    int  err_count      = 0;
    int  words_accepted = 0;
    int  words_ignored  = 0;
    int  results_seen   = 0;
    int  reg_writes     = 0;

    bit  rx_quiet    = 1'b0;
    bit  rx_hold_req = 1'b0;
    int  rx_hold_len = 0;

    multi_channel_pwm_ramp_h_bridge dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout: %0d results still due", due_bridge_words.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTS)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // one update of the slew / ramp model; channel state is advanced in place
    task automatic bridge_update(input logic [IN_TDATA_W-1:0] w, output bit gives,
                                 output t_result r);
        int ch, en, req, dir, last, tgt, cur, lvl, capped;
        int slew, step, dmax;
        ch   = int'(w[1:0]);
        en   = int'(w[2]);
        req  = int'(w[10:3]);
        dir  = int'(w[12:11]);
        slew = int'(slew_limit_q);
        step = int'(ramp_step_q);
        dmax = int'(duty_max_q);
        r = '0;
        gives = 1'b0;
        if (ch >= CHANNEL_COUNT_DEF)
            return;
        gives = 1'b1;
        r.out_channel = CH_W'(ch);
        if (en == 0) begin
            duty_mem[ch] = '0;
            return;
        end
        last = int'(target_mem[ch]);
        tgt  = req;
        if (req > last && req - last > slew)
            tgt = last + slew;
        else if (req <= last && last - req > slew)
            tgt = last - slew;
        target_mem[ch] = DUTY_W'(tgt);
        cur = int'(duty_mem[ch]);
        lvl = cur;
        if (cur < tgt) begin
            lvl = cur + step;
            if (lvl > 255)
                lvl = 255;
            if (lvl > tgt)
                lvl = tgt;
        end else if (cur > tgt) begin
            lvl = (cur - tgt <= step) ? tgt : cur - step;
        end
        duty_mem[ch] = DUTY_W'(lvl);
        capped = (lvl > dmax) ? dmax : lvl;
        r.limited_target = DUTY_W'(tgt);
        r.ramp_level     = DUTY_W'(lvl);
        r.leg_a_duty     = DUTY_W'((dir == DIR_FWD) ? capped : 0);
        r.leg_b_duty     = DUTY_W'((dir == DIR_REV) ? capped : 0);
    endtask

    always @(posedge i_clk) begin : monitor
        bit         gives;
        t_result    pred;
        t_result    got;
        t_result    want;
        t_typed_chk tc;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                bridge_update(s_axis_tdata, gives, pred);
                words_accepted++;
                if (!gives)
                    words_ignored++;
                tc.kind = CHK_PREDICT;
                tc.want = '0;
                if (typed_checks.size() > 0)
                    tc = typed_checks.pop_front();
                case (tc.kind)
                    CHK_PREDICT: if (gives) due_bridge_words.push_back(pred);
                    CHK_TYPED:   due_bridge_words.push_back(tc.want);
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.out_channel    = m_axis_tdata[1:0];
                got.limited_target = m_axis_tdata[9:2];
                got.ramp_level     = m_axis_tdata[17:10];
                got.leg_a_duty     = m_axis_tdata[25:18];
                got.leg_b_duty     = m_axis_tdata[33:26];
                results_seen++;
                if (due_bridge_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
                end else begin
                    want = due_bridge_words.pop_front();
                    check_field("out_channel", int'(got.out_channel),
                                int'(want.out_channel));
                    check_field("limited_target", int'(got.limited_target),
                                int'(want.limited_target));
                    check_field("ramp_level", int'(got.ramp_level),
                                int'(want.ramp_level));
                    check_field("leg_a_duty", int'(got.leg_a_duty),
                                int'(want.leg_a_duty));
                    check_field("leg_b_duty", int'(got.leg_b_duty),
                                int'(want.leg_b_duty));
                end
            end
        end
    end

    // output side: random ready bursts, a counted hold-off on request
    initial begin : receiver
        bit rdy;
        int burst;
        rdy   = 1'b1;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                rx_hold_req = 1'b0;
                repeat (rx_hold_len - 1) @(negedge i_clk);
            end else if (rx_quiet) begin
                m_axis_tready <= 1'b1;
            end else begin
                if (burst == 0) begin
                    if (rdy && $urandom_range(0, 2) == 0) begin
                        rdy   = 1'b0;
                        burst = int'($urandom_range(1, 17));
                    end else begin
                        rdy   = 1'b1;
                        burst = int'($urandom_range(1, 40));
                    end
                end
                m_axis_tready <= rdy;
                burst--;
            end
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack_word(input int ch, input bit en,
                                                       input int req, input t_dir dir);
        logic [IN_TDATA_W-1:0] w;
        w        = '0;
        w[1:0]   = CH_W'(ch);
        w[2]     = en;
        w[10:3]  = DUTY_W'(req);
        w[12:11] = dir;
        return w;
    endfunction

    task automatic offer_word(input logic [IN_TDATA_W-1:0] w);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic idle_tx(input int n);
        repeat (n) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_TDATA_W'($urandom);
        end
    endtask

    task automatic wait_idle();
        idle_tx(1);
        while (due_bridge_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= DUTY_W'(value);
        case (idx)
            CFG_RAMP_STEP:  ramp_step_q  = DUTY_W'(value);
            CFG_SLEW_LIMIT: slew_limit_q = DUTY_W'(value);
            CFG_DUTY_MAX:   duty_max_q   = DUTY_W'(value);
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_plan_row item_row(input int ch, input bit en, input int req,
                                           input t_dir dir, input t_chk_kind kind,
                                           input int w_tgt = 0, input int w_lvl = 0,
                                           input int w_a = 0, input int w_b = 0);
        t_plan_row r;
        r.cfg_write           = 1'b0;
        r.idx                 = CFG_RAMP_STEP;
        r.value               = 0;
        r.ch                  = ch;
        r.en                  = en;
        r.req                 = req;
        r.dir                 = dir;
        r.kind                = kind;
        r.want.out_channel    = CH_W'(ch);
        r.want.limited_target = DUTY_W'(w_tgt);
        r.want.ramp_level     = DUTY_W'(w_lvl);
        r.want.leg_a_duty     = DUTY_W'(w_a);
        r.want.leg_b_duty     = DUTY_W'(w_b);
        return r;
    endfunction

    function automatic t_plan_row cfg_row(input t_cfg_idx idx, input int value);
        t_plan_row r;
        r           = item_row(0, 1'b0, 0, DIR_STOP, CHK_PREDICT);
        r.cfg_write = 1'b1;
        r.idx       = idx;
        r.value     = value;
        return r;
    endfunction

    initial begin : stimulus
        t_plan_row  plan [$];
        t_plan_row  row;
        t_typed_chk tc;
        int phase_ramp [PHASES] = '{5, 255, 1, 0, 255, -1, -1};
        int phase_slew [PHASES] = '{25, 255, 1, 255, 0, -1, -1};
        int phase_max  [PHASES] = '{255, 255, 128, 200, 0, -1, -1};
        int in_range, calm_left, ch, req, off, sel;
        bit en;
        t_dir dir;

        plan.push_back(item_row(0, 1'b1, 0,   DIR_FWD,      CHK_TYPED, 0, 0, 0, 0));
        plan.push_back(item_row(0, 1'b1, 255, DIR_FWD,      CHK_TYPED, 25, 5, 5, 0));
        plan.push_back(item_row(1, 1'b1, 255, DIR_REV,      CHK_TYPED, 25, 5, 0, 5));
        plan.push_back(item_row(2, 1'b1, 10,  DIR_STOP_ALT, CHK_TYPED, 10, 5, 0, 0));
        plan.push_back(item_row(3, 1'b1, 200, DIR_FWD,      CHK_SILENT));
        plan.push_back(item_row(3, 1'b0, 0,   DIR_REV,      CHK_SILENT));
        plan.push_back(item_row(2, 1'b1, 10,  DIR_STOP,     CHK_TYPED, 10, 10, 0, 0));
        plan.push_back(item_row(0, 1'b0, 255, DIR_FWD,      CHK_TYPED, 0, 0, 0, 0));
        plan.push_back(item_row(0, 1'b1, 255, DIR_FWD,      CHK_PREDICT));
        plan.push_back(item_row(0, 1'b1, 0,   DIR_REV,      CHK_PREDICT));
        plan.push_back(item_row(1, 1'b1, 0,   DIR_FWD,      CHK_PREDICT));
        plan.push_back(cfg_row(CFG_RAMP_STEP, 255));
        plan.push_back(cfg_row(CFG_SLEW_LIMIT, 255));
        plan.push_back(cfg_row(CFG_DUTY_MAX, 100));
        plan.push_back(item_row(1, 1'b1, 255, DIR_FWD,      CHK_TYPED, 255, 255, 100, 0));
        plan.push_back(item_row(1, 1'b1, 0,   DIR_REV,      CHK_TYPED, 0, 0, 0, 0));
        plan.push_back(item_row(0, 1'b1, 200, DIR_REV,      CHK_PREDICT));
        plan.push_back(cfg_row(CFG_RAMP_STEP, 0));
        plan.push_back(cfg_row(CFG_SLEW_LIMIT, 0));
        plan.push_back(cfg_row(CFG_DUTY_MAX, 0));
        plan.push_back(item_row(2, 1'b1, 200, DIR_FWD,      CHK_TYPED, 10, 10, 0, 0));
        plan.push_back(item_row(0, 1'b1, 0,   DIR_REV,      CHK_PREDICT));
        plan.push_back(item_row(2, 1'b0, 255, DIR_FWD,      CHK_TYPED, 0, 0, 0, 0));
        plan.push_back(item_row(2, 1'b1, 255, DIR_FWD,      CHK_TYPED, 10, 0, 0, 0));
        plan.push_back(cfg_row(CFG_RAMP_STEP, RAMP_STEP_RST));
        plan.push_back(cfg_row(CFG_SLEW_LIMIT, SLEW_LIMIT_RST));
        plan.push_back(cfg_row(CFG_DUTY_MAX, DUTY_MAX_RST));
        plan.push_back(item_row(3, 1'b1, 255, DIR_STOP_ALT, CHK_SILENT));
        plan.push_back(item_row(1, 1'b1, 30,  DIR_FWD,      CHK_PREDICT));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            row = plan[i];
            if (row.cfg_write) begin
                write_reg(row.idx, row.value);
            end else begin
                tc.kind = row.kind;
                tc.want = row.want;
                typed_checks.push_back(tc);
                offer_word(pack_word(row.ch, row.en, row.req, row.dir));
            end
        end

        calm_left = 0;
        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_RAMP_STEP,
                      phase_ramp[p] < 0 ? int'($urandom_range(0, 255)) : phase_ramp[p]);
            write_reg(CFG_SLEW_LIMIT,
                      phase_slew[p] < 0 ? int'($urandom_range(0, 255)) : phase_slew[p]);
            write_reg(CFG_DUTY_MAX,
                      phase_max[p] < 0 ? int'($urandom_range(0, 255)) : phase_max[p]);
            if (p == PHASES - 1)
                rx_quiet = 1'b1;
            in_range = 0;
            while (in_range < PHASE_WORDS) begin
                ch  = ($urandom_range(0, 15) == 0) ? 3
                                                   : int'($urandom_range(0, CHANNEL_COUNT_DEF - 1));
                en  = ($urandom_range(0, 9) != 0);
                dir = t_dir'($urandom_range(0, 3));
                sel = int'($urandom_range(0, 9));
                if (sel < 4 || ch >= CHANNEL_COUNT_DEF) begin
                    req = int'($urandom_range(0, 255));
                end else if (sel == 4) begin
                    req = 0;
                end else if (sel == 5) begin
                    req = 255;
                end else begin
                    // stay near the slew window so ramps settle and clamp
                    off = int'($urandom_range(0, 2 * int'(slew_limit_q) + 4));
                    req = int'(target_mem[ch]) + off - int'(slew_limit_q) - 2;
                    if (req < 0)
                        req = 0;
                    if (req > 255)
                        req = 255;
                end
                if (p != PHASES - 1) begin
                    if (calm_left > 0)
                        calm_left--;
                    else if ($urandom_range(0, 40) == 0)
                        calm_left = int'($urandom_range(20, 60));
                    else if ($urandom_range(0, 4) == 0)
                        idle_tx(int'($urandom_range(1, 17)));
                end
                offer_word(pack_word(ch, en, req, dir));
                if (ch < CHANNEL_COUNT_DEF)
                    in_range++;
                if (p == 1 && in_range == 40 && ch < CHANNEL_COUNT_DEF) begin
                    rx_hold_len = 150;
                    rx_hold_req = 1'b1;
                    calm_left   = 60;
                end
                if (p == 2 && in_range == 60 && ch < CHANNEL_COUNT_DEF)
                    wait_idle();
            end
        end

        wait_idle();
        $display("Covered %0d words (%0d on unused channel), %0d results checked,",
                 words_accepted, words_ignored, results_seen);
        $display("%0d register writes over %0d random settings plus the directed table",
                 reg_writes, PHASES);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== multi_channel_pwm_ramp_h_bridge.f =====
hdl/mcpwm_pkg.sv
hdl/mcpwm_in_stage.sv
hdl/mcpwm_update.sv
hdl/mcpwm_out_stage.sv
hdl/multi_channel_pwm_ramp_h_bridge.sv
bench/tb.sv
